// File: rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared widths, phase and action codes, register indexes and reset values for the
// 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int TIMER_WIDTH   = 10;
  localparam int BITS_PER_BYTE = 8;
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 10;
  localparam int BITS_W        = 4;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef logic [TIMER_WIDTH-1:0] timer_t;
  typedef logic [BITS_W-1:0]      bitcnt_t;
  typedef logic [2:0]             phase_t;
  typedef logic [2:0]             action_t;

  // phase codes
  localparam phase_t PH_IDLE      = 3'd0;
  localparam phase_t PH_RST_LOW   = 3'd1;
  localparam phase_t PH_RST_WAIT  = 3'd2;
  localparam phase_t PH_RST_RECOV = 3'd3;
  localparam phase_t PH_WR_LOW    = 3'd4;
  localparam phase_t PH_RD_LOW    = 3'd5;
  localparam phase_t PH_RD_WAIT   = 3'd6;
  localparam phase_t PH_SLOT_REL  = 3'd7;

  // action codes
  localparam action_t ACT_NONE      = 3'd0;
  localparam action_t ACT_RESET     = 3'd1;
  localparam action_t ACT_WR_BYTE   = 3'd2;
  localparam action_t ACT_RD_BYTE   = 3'd3;
  localparam action_t ACT_WR_BIT    = 3'd4;
  localparam action_t ACT_RD_BIT    = 3'd5;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RESET_RECOV   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WR_ONE_LOW    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WR_SLOT       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RD_LOW        = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RD_SAMPLE     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_RD_RECOV      = 3'd7;

  localparam logic [CFG_DATA_W-1:0] RESET_LOW_DEF     = 10'd750;
  localparam logic [CFG_DATA_W-1:0] PRESENCE_WAIT_DEF = 10'd100;
  localparam logic [CFG_DATA_W-1:0] RESET_RECOV_DEF   = 10'd400;
  localparam logic [CFG_DATA_W-1:0] WR_ONE_LOW_DEF    = 10'd5;
  localparam logic [CFG_DATA_W-1:0] WR_SLOT_DEF       = 10'd75;
  localparam logic [CFG_DATA_W-1:0] RD_LOW_DEF        = 10'd5;
  localparam logic [CFG_DATA_W-1:0] RD_SAMPLE_DEF     = 10'd5;
  localparam logic [CFG_DATA_W-1:0] RD_RECOV_DEF      = 10'd60;

endpackage

// File: rtl/one_wire_bus_master_unit.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// 1-Wire bus master; each request is one microsecond tick of bus timing.
// ----------------------------------------------------------------------------
// The result of a request is registered in the output register in the cycle after it is accepted.
// Throughput: one request per cycle while the output register is not stalled; each request yields exactly one result.
// The tick logic (phase, timer, shift register) is one combinational pass
// between the state registers and the output register.
// Reset (rst, synchronous): phase idle, counters clear, timing registers
// return to their defaults, output register empty.
module one_wire_bus_master_unit (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata: action[2:0], data_in[10:3], line_in[11], zero pad
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [owbm_pkg::IN_TDATA_W-1:0] s_tdata,
  // m_tdata: drive_low[0], busy_res[1], done_res[2], presence_fail[3],
  //          read_data[11:4], rejected[12], zero pad
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [owbm_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [owbm_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [owbm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import owbm_pkg::*;

  logic [CFG_DATA_W-1:0] regs [NUM_REGS];

  phase_t  phase,       phase_next;
  timer_t  phase_timer, phase_timer_next;
  bitcnt_t bits_left,   bits_left_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic    reading,     reading_next;
  logic    single_bit,  single_bit_next;
  logic    presence_flag, presence_flag_next;

  logic       out_valid;
  logic [OUT_TDATA_W-1:0] out_data;

  action_t    act;
  logic [7:0] din;
  logic       line;
  logic       accept;

  logic       busy, drive, done, rej;
  logic [7:0] odata;
  logic       rel_go, end_go;
  timer_t     rel_t;
  timer_t     lo_t, slot_t;

  assign act  = s_tdata[2:0];
  assign din  = s_tdata[10:3];
  assign line = s_tdata[11];

  assign s_tready  = !out_valid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign lo_t   = timer_t'(regs[REG_WR_ONE_LOW]);
  assign slot_t = timer_t'(regs[REG_WR_SLOT]);

  always_comb begin
    phase_next         = phase;
    phase_timer_next   = phase_timer;
    bits_left_next     = bits_left;
    shift_byte_next    = shift_byte;
    reading_next       = reading;
    single_bit_next    = single_bit;
    presence_flag_next = presence_flag;
    done   = 1'b0;
    odata  = 8'd0;
    rej    = 1'b0;
    rel_go = 1'b0;
    end_go = 1'b0;
    rel_t  = '0;

    // command start, same tick
    if (phase == PH_IDLE) begin
      if (act >= ACT_RESET && act <= ACT_RD_BIT) begin
        single_bit_next = (act == ACT_WR_BIT) || (act == ACT_RD_BIT);
        reading_next    = (act == ACT_RD_BYTE) || (act == ACT_RD_BIT);
        if (act == ACT_RESET) begin
          phase_next       = PH_RST_LOW;
          phase_timer_next = timer_t'(regs[REG_RESET_LOW]);
        end else begin
          bits_left_next = single_bit_next ? bitcnt_t'(1) : bitcnt_t'(BITS_PER_BYTE);
          if (reading_next) begin
            shift_byte_next  = 8'd0;
            phase_next       = PH_RD_LOW;
            phase_timer_next = timer_t'(regs[REG_RD_LOW]);
          end else begin
            shift_byte_next  = single_bit_next ? {7'd0, din[0]} : din;
            phase_next       = PH_WR_LOW;
            phase_timer_next = shift_byte_next[0] ? lo_t : slot_t;
          end
        end
      end
    end else if (act != ACT_NONE) begin
      rej = 1'b1;
    end

    busy  = (phase_next != PH_IDLE);
    drive = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW) ||
            (phase_next == PH_RD_LOW);

    case (phase_next)
      PH_IDLE: begin
      end
      PH_RST_LOW: begin
        if (phase_timer_next <= timer_t'(1)) begin
          phase_next       = PH_RST_WAIT;
          phase_timer_next = timer_t'(regs[REG_PRESENCE_WAIT]);
        end else begin
          phase_timer_next = phase_timer_next - timer_t'(1);
        end
      end
      PH_RST_WAIT: begin
        if (phase_timer_next == '0) begin
          presence_flag_next = line;
          phase_next         = PH_RST_RECOV;
          phase_timer_next   = timer_t'(regs[REG_RESET_RECOV]);
          if (phase_timer_next == '0) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
        end else begin
          phase_timer_next = phase_timer_next - timer_t'(1);
        end
      end
      PH_RST_RECOV: begin
        if (phase_timer_next <= timer_t'(1)) begin
          phase_next       = PH_IDLE;
          phase_timer_next = '0;
          done             = 1'b1;
        end else begin
          phase_timer_next = phase_timer_next - timer_t'(1);
        end
      end
      PH_WR_LOW: begin
        if (phase_timer_next <= timer_t'(1)) begin
          rel_go = 1'b1;
          if (shift_byte_next[0] && slot_t > lo_t) rel_t = slot_t - lo_t;
        end else begin
          phase_timer_next = phase_timer_next - timer_t'(1);
        end
      end
      PH_RD_LOW: begin
        if (phase_timer_next <= timer_t'(1)) begin
          phase_next       = PH_RD_WAIT;
          phase_timer_next = timer_t'(regs[REG_RD_SAMPLE]);
        end else begin
          phase_timer_next = phase_timer_next - timer_t'(1);
        end
      end
      PH_RD_WAIT: begin
        if (phase_timer_next == '0) begin
          shift_byte_next = {line, shift_byte_next[7:1]};
          rel_go          = 1'b1;
          rel_t           = timer_t'(regs[REG_RD_RECOV]);
        end else begin
          phase_timer_next = phase_timer_next - timer_t'(1);
        end
      end
      PH_SLOT_REL: begin
        if (phase_timer_next <= timer_t'(1)) end_go = 1'b1;
        else phase_timer_next = phase_timer_next - timer_t'(1);
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (rel_go) begin
      phase_next       = PH_SLOT_REL;
      phase_timer_next = rel_t;
      if (rel_t == '0) end_go = 1'b1;
    end

    // end of a bit slot: next bit or finish
    if (end_go) begin
      if (!reading_next) shift_byte_next = {1'b0, shift_byte_next[7:1]};
      if (bits_left_next <= bitcnt_t'(1)) begin
        bits_left_next   = '0;
        phase_next       = PH_IDLE;
        phase_timer_next = '0;
        done             = 1'b1;
        if (reading_next) begin
          odata = single_bit_next ? {7'd0, shift_byte_next[7]} : shift_byte_next;
        end
      end else begin
        bits_left_next = bits_left_next - bitcnt_t'(1);
        if (reading_next) begin
          phase_next       = PH_RD_LOW;
          phase_timer_next = timer_t'(regs[REG_RD_LOW]);
        end else begin
          phase_next       = PH_WR_LOW;
          phase_timer_next = shift_byte_next[0] ? lo_t : slot_t;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_RESET_LOW]     <= RESET_LOW_DEF;
      regs[REG_PRESENCE_WAIT] <= PRESENCE_WAIT_DEF;
      regs[REG_RESET_RECOV]   <= RESET_RECOV_DEF;
      regs[REG_WR_ONE_LOW]    <= WR_ONE_LOW_DEF;
      regs[REG_WR_SLOT]       <= WR_SLOT_DEF;
      regs[REG_RD_LOW]        <= RD_LOW_DEF;
      regs[REG_RD_SAMPLE]     <= RD_SAMPLE_DEF;
      regs[REG_RD_RECOV]      <= RD_RECOV_DEF;
    end else if (cfg_valid && cfg_ready) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_timer   <= '0;
      bits_left     <= '0;
      shift_byte    <= 8'd0;
      reading       <= 1'b0;
      single_bit    <= 1'b0;
      presence_flag <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      phase_timer   <= phase_timer_next;
      bits_left     <= bits_left_next;
      shift_byte    <= shift_byte_next;
      reading       <= reading_next;
      single_bit    <= single_bit_next;
      presence_flag <= presence_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= {3'd0, rej, odata, presence_flag_next, done, busy, drive};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// File: rtl/owbm_checker.sv
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks on the result stream of the 1-Wire bus master.
// ----------------------------------------------------------------------------
module owbm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [owbm_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import owbm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[1])
    else $error("bus driven low outside a command");

  // a write-zero slot may finish on its last low tick
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1])
    else $error("done without busy");

  a_data_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[11:4] != 8'd0) |-> m_tdata[2])
    else $error("read data outside the finishing tick");

  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[12] |-> m_tdata[1])
    else $error("request rejected while idle");

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (.*);
